// File: rtl/sensor_frame_crc_convert_assert.svh
// Assertion macros used by the verification checker of this block.
`ifndef SENSOR_FRAME_CRC_CONVERT_ASSERT_SVH
`define SENSOR_FRAME_CRC_CONVERT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SFCC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sfcc: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define SFCC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sfcc: next-cycle check failed");

`endif

// File: rtl/sfcc_pkg.sv
`timescale 1ns / 1ps

package sfcc_pkg;

    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // Scaling by 267/1000 and 153/1000 is done as a multiply by a rounded-up
    // reciprocal and a right shift; with a 27-bit shift the error stays below
    // one thousandth for every 16-bit word, so the floor is exact.
    localparam int SCALE_SHIFT = 27;
    localparam int WORD_W = 16;
    localparam int TEMP_MAG_W = 26;
    localparam int HUM_MAG_W = 25;
    localparam logic [TEMP_MAG_W-1:0] TEMP_MAG = 26'd35836134;
    localparam logic [HUM_MAG_W-1:0] HUM_MAG = 25'd20535313;
    localparam int TEMP_PROD_W = WORD_W + TEMP_MAG_W;
    localparam int HUM_PROD_W = WORD_W + HUM_MAG_W;
    localparam int TEMP_W = 15;
    localparam int HUM_W = 14;
    localparam logic [TEMP_W:0] TEMP_OFFSET = 16'd4500;

    typedef enum logic [2:0] {
        POS_T_HI  = 3'd0,
        POS_T_LO  = 3'd1,
        POS_T_CRC = 3'd2,
        POS_H_HI  = 3'd3,
        POS_H_LO  = 3'd4,
        POS_H_CRC = 3'd5
    } pos_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TEMP_CRC = 2'd1,
        STATUS_HUM_CRC  = 2'd2
    } status_t;

    typedef struct packed {
        logic              fire;
        status_t           status;
        logic [WORD_W-1:0] temp_word;
        logic [WORD_W-1:0] hum_word;
    } frame_res_t;

endpackage

// File: rtl/sfcc_crc8.sv
`timescale 1ns / 1ps

// One byte of CRC-8, polynomial 0x31, MSB first, unrolled over the eight bits.
module sfcc_crc8
(
    input  logic [7:0] crc_in,
    input  logic [7:0] data,
    output logic [7:0] crc_out
);

    always_comb
    begin
        logic [7:0] c;
        c = crc_in ^ data;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
            begin
                c = {c[6:0], 1'b0} ^ sfcc_pkg::CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        crc_out = c;
    end

endmodule

// File: rtl/sfcc_frame.sv
`timescale 1ns / 1ps

// Byte sequencer: tracks the position in the frame, runs the CRC and
// collects the two words. Reports a finished frame on the last byte's beat.
module sfcc_frame
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                beat,
    input  logic [7:0]          frame_byte,
    input  logic                frame_start,
    output sfcc_pkg::frame_res_t res
);

    sfcc_pkg::pos_t pos_reg, pos_next, pos_eff;
    logic [7:0]  running_crc_reg, running_crc_next;
    logic [15:0] word_buffer_reg, word_buffer_next;
    logic [15:0] temperature_word_reg, temperature_word_next;
    logic        temperature_bad_reg, temperature_bad_next;
    logic [7:0]  crc_seed, crc_out;

    sfcc_crc8 u_crc8
    (
        .crc_in  (crc_seed),
        .data    (frame_byte),
        .crc_out (crc_out)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg              <= sfcc_pkg::POS_T_HI;
            running_crc_reg      <= sfcc_pkg::CRC_INIT;
            word_buffer_reg      <= '0;
            temperature_word_reg <= '0;
            temperature_bad_reg  <= 1'b0;
        end
        else
        begin
            pos_reg              <= pos_next;
            running_crc_reg      <= running_crc_next;
            word_buffer_reg      <= word_buffer_next;
            temperature_word_reg <= temperature_word_next;
            temperature_bad_reg  <= temperature_bad_next;
        end
    end

    always_comb
    begin
        pos_eff = frame_start ? sfcc_pkg::POS_T_HI : pos_reg;

        // Only the low byte of a word continues a running CRC.
        if (pos_eff == sfcc_pkg::POS_T_LO || pos_eff == sfcc_pkg::POS_H_LO)
        begin
            crc_seed = running_crc_reg;
        end
        else
        begin
            crc_seed = sfcc_pkg::CRC_INIT;
        end

        pos_next              = pos_reg;
        running_crc_next      = running_crc_reg;
        word_buffer_next      = word_buffer_reg;
        temperature_word_next = temperature_word_reg;
        temperature_bad_next  = temperature_bad_reg;

        res.fire      = 1'b0;
        res.temp_word = temperature_word_reg;
        res.hum_word  = word_buffer_reg;
        if (temperature_bad_reg)
        begin
            res.status = sfcc_pkg::STATUS_TEMP_CRC;
        end
        else if (running_crc_reg != frame_byte)
        begin
            res.status = sfcc_pkg::STATUS_HUM_CRC;
        end
        else
        begin
            res.status = sfcc_pkg::STATUS_OK;
        end

        if (beat)
        begin
            unique case (pos_eff) inside
                sfcc_pkg::POS_T_LO, sfcc_pkg::POS_H_LO:
                begin
                    running_crc_next = crc_out;
                    word_buffer_next = {word_buffer_reg[15:8], frame_byte};
                    pos_next = (pos_eff == sfcc_pkg::POS_H_LO) ? sfcc_pkg::POS_H_CRC
                                                               : sfcc_pkg::POS_T_CRC;
                end
                sfcc_pkg::POS_T_CRC:
                begin
                    temperature_bad_next  = (running_crc_reg != frame_byte);
                    temperature_word_next = word_buffer_reg;
                    running_crc_next      = sfcc_pkg::CRC_INIT;
                    pos_next              = sfcc_pkg::POS_H_HI;
                end
                sfcc_pkg::POS_H_CRC:
                begin
                    res.fire         = 1'b1;
                    running_crc_next = sfcc_pkg::CRC_INIT;
                    pos_next         = sfcc_pkg::POS_T_HI;
                end
                default:
                begin
                    // High byte of either word; unused codes act as the first byte.
                    running_crc_next = crc_out;
                    word_buffer_next = {frame_byte, 8'h00};
                    pos_next = (pos_eff == sfcc_pkg::POS_H_HI) ? sfcc_pkg::POS_H_LO
                                                               : sfcc_pkg::POS_T_LO;
                end
            endcase
        end
    end

endmodule

// File: rtl/sfcc_scale.sv
`timescale 1ns / 1ps

// Converts the finished frame's words to centi-units and holds the result
// in the output register until it is taken.
module sfcc_scale
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  sfcc_pkg::frame_res_t         res,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic signed [sfcc_pkg::TEMP_W-1:0] temperature_centi,
    output logic [sfcc_pkg::HUM_W-1:0]   humidity_centi,
    output logic [1:0]                   frame_status
);

    logic [sfcc_pkg::TEMP_PROD_W-1:0] temp_prod;
    logic [sfcc_pkg::HUM_PROD_W-1:0]  hum_prod;
    logic [sfcc_pkg::TEMP_W:0]        temp_wide;
    logic                             out_valid_reg, out_valid_next;
    logic [sfcc_pkg::TEMP_W-1:0]      temp_reg, temp_next;
    logic [sfcc_pkg::HUM_W-1:0]       hum_reg, hum_next;
    logic [1:0]                       status_reg, status_next;

    assign temp_prod = sfcc_pkg::TEMP_PROD_W'(res.temp_word)
                     * sfcc_pkg::TEMP_PROD_W'(sfcc_pkg::TEMP_MAG);
    assign hum_prod  = sfcc_pkg::HUM_PROD_W'(res.hum_word)
                     * sfcc_pkg::HUM_PROD_W'(sfcc_pkg::HUM_MAG);

    always_comb
    begin
        temp_wide = {1'b0, temp_prod[sfcc_pkg::SCALE_SHIFT +: sfcc_pkg::TEMP_W]}
                  - sfcc_pkg::TEMP_OFFSET;
        temp_next   = temp_wide[sfcc_pkg::TEMP_W-1:0];
        hum_next    = hum_prod[sfcc_pkg::SCALE_SHIFT +: sfcc_pkg::HUM_W];
        status_next = res.status;

        if (res.fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.fire)
        begin
            temp_reg   <= temp_next;
            hum_reg    <= hum_next;
            status_reg <= status_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign temperature_centi = temp_reg;
    assign humidity_centi    = hum_reg;
    assign frame_status      = status_reg;

endmodule

// File: rtl/sensor_frame_crc_convert.sv
`timescale 1ns / 1ps

// Checks and converts six-byte temperature/humidity frames (temperature word,
// its CRC-8, humidity word, its CRC-8; CRC polynomial 0x31, seed 0xFF per word).
// One byte is taken per beat, one every clock cycle, whenever the output register
// is empty or its result is taken in the same cycle; while a result waits at the
// output with out_ready low, every byte is held off until the result is taken.
// The result of a frame appears in the cycle after its sixth byte, from a single
// result register fed by one constant multiply per value. frame_start forces the
// byte to be treated as the first of a frame; without it, frames run back to
// back. A temperature CRC error is reported in preference to a humidity CRC
// error, and both values are always converted.
module sensor_frame_crc_convert
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          frame_byte,
    input  logic                                frame_start,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [sfcc_pkg::TEMP_W-1:0]  temperature_centi,
    output logic [sfcc_pkg::HUM_W-1:0]          humidity_centi,
    output logic [1:0]                          frame_status
);

    sfcc_pkg::frame_res_t frame_res;
    logic                 beat;

    // Only a last byte can produce a result, but gating on that would put the
    // byte into the ready path; stalling any byte while the output is full is enough.
    assign in_ready = !out_valid || out_ready;
    assign beat     = in_valid && in_ready;

    sfcc_frame u_frame
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .beat        (beat),
        .frame_byte  (frame_byte),
        .frame_start (frame_start),
        .res         (frame_res)
    );

    sfcc_scale u_scale
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .res               (frame_res),
        .out_ready         (out_ready),
        .out_valid         (out_valid),
        .temperature_centi (temperature_centi),
        .humidity_centi    (humidity_centi),
        .frame_status      (frame_status)
    );

endmodule

// File: rtl/sfcc_checker.sv
`timescale 1ns / 1ps

`include "sensor_frame_crc_convert_assert.svh"

module sfcc_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic signed [sfcc_pkg::TEMP_W-1:0] temperature_centi,
    input logic [sfcc_pkg::HUM_W-1:0]         humidity_centi,
    input logic [1:0]                         frame_status
);

    // A held result must not change while the consumer stalls.
    `SFCC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(temperature_centi) && $stable(humidity_centi) && $stable(frame_status))

    // An empty output register never blocks the input side.
    `SFCC_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)

    // A full, stalled output register must hold off new bytes.
    `SFCC_ASSERT_NOW(a_no_overrun, clk, rst_n, out_valid && !out_ready, !in_ready)

    // The status never goes past the humidity CRC code.
    `SFCC_ASSERT_NOW(a_status_code, clk, rst_n, out_valid, frame_status <= sfcc_pkg::STATUS_HUM_CRC)

    // Humidity of a 16-bit word scaled by 0.153 stays at or below 10026.
    `SFCC_ASSERT_NOW(a_hum_range, clk, rst_n, out_valid, humidity_centi <= 14'd10026)

endmodule

bind sensor_frame_crc_convert sfcc_checker u_sfcc_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .in_ready          (in_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .temperature_centi (temperature_centi),
    .humidity_centi    (humidity_centi),
    .frame_status      (frame_status)
);
